// ===== hw/rtl/membership_rumor_merge_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Membership rumor merge table: assertion macros
// Shared concurrent-assertion shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MEMBERSHIP_RUMOR_MERGE_TABLE_CORE_DEFINES_SVH
`define MEMBERSHIP_RUMOR_MERGE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MRMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MRMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mrmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Membership rumor merge table: shared package
// Field widths, codes, table geometry and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int STAT_W = 2;
    localparam int INC_W  = 32;
    localparam int TIME_W = 32;
    localparam int EV_W   = 3;
    localparam int EP_W   = ADDR_W + PORT_W;

    // Stream packing
    localparam int S_FIELDS_W = ADDR_W + PORT_W + STAT_W + INC_W + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ADDR_W + PORT_W + STAT_W + INC_W + 1 + INC_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;
    localparam logic [TIME_W-1:0]    TIMEOUT_RESET   = 32'd1000;

    // Item kinds
    localparam logic KIND_RUMOR = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Member status
    localparam logic [STAT_W-1:0] STAT_ALIVE   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SUSPECT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DEAD    = 2'd2;

    // Event codes
    localparam logic [EV_W-1:0] EV_IGNORED = 3'd0;
    localparam logic [EV_W-1:0] EV_LEARNED = 3'd1;
    localparam logic [EV_W-1:0] EV_CHANGED = 3'd2;
    localparam logic [EV_W-1:0] EV_SAME    = 3'd3;
    localparam logic [EV_W-1:0] EV_REFUTED = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd5;
    localparam logic [EV_W-1:0] EV_EXPIRED = 3'd6;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUMOR_SCAN,
        ST_MERGE,
        ST_TICK_SCAN,
        ST_TICK_DONE
    } state_t;

    // One input item
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] subject_address;
        logic [PORT_W-1:0] subject_port;
        logic [STAT_W-1:0] reported_state;
        logic [INC_W-1:0]  reported_incarnation;
        logic [TIME_W-1:0] current_time;
    } item_t;

    // One result item
    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [ADDR_W-1:0] member_address;
        logic [PORT_W-1:0] member_port;
        logic [STAT_W-1:0] member_state;
        logic [INC_W-1:0]  member_incarnation;
        logic              spread_again;
        logic [INC_W-1:0]  own_incarnation_now;
        logic              last_result;
    } result_t;

    // Configuration register set
    typedef struct packed {
        logic [ADDR_W-1:0] own_address;
        logic [PORT_W-1:0] own_port;
        logic [TIME_W-1:0] suspect_grace;
    } cfg_t;

    // One stored table entry
    typedef struct packed {
        logic [EP_W-1:0]   endpoint;
        logic [STAT_W-1:0] status;
        logic [INC_W-1:0]  incarnation;
        logic [TIME_W-1:0] deadline;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/membership_rumor_merge_table_core.sv =====
// Flow: a rumor for an empty or own endpoint goes straight to the merge step; any other rumor
// scans the table up to its matching entry, or walks all 32 entries when none matches.
// A tick walks all 32 entries, then closes with a last result.
// Throughput: one item at a time; input is ready again once the last result is
// registered, and a result waiting on m_tready stalls the merge step and the expiry scan.
// Reset: async active low; clears entry valid bits, own incarnation, config to defaults.
// ----------------------------------------------------------------------------
// Membership rumor merge table core
// Stream wrapper: configuration registers, input unpacking, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module membership_rumor_merge_table_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // subject_address, subject_port, reported_state, reported_incarnation, current_time
    input  wire logic [mrmt_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  wire logic [0:0]                        s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // member_address, member_port, member_state, member_incarnation, spread_again,
    // own_incarnation_now
    output logic      [mrmt_pkg::M_TDATA_W-1:0]    m_tdata,
    // event_res
    output logic      [mrmt_pkg::EV_W-1:0]         m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [mrmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mrmt_pkg::cfg_t    cfg_reg;
    mrmt_pkg::item_t   item;
    mrmt_pkg::result_t eng_res;
    mrmt_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              eng_idle;
    logic              eng_push;
    logic              start;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address   <= '0;
            cfg_reg.own_port      <= '0;
            cfg_reg.suspect_grace <= mrmt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrmt_pkg::CFG_OWN_ADDRESS: cfg_reg.own_address <= cfg_data;
                mrmt_pkg::CFG_OWN_PORT:    cfg_reg.own_port <= cfg_data[mrmt_pkg::PORT_W-1:0];
                mrmt_pkg::CFG_TIMEOUT:     cfg_reg.suspect_grace <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Unpack the input transaction
    assign item.kind                 = s_tuser[0];
    assign item.subject_address      = s_tdata[31:0];
    assign item.subject_port         = s_tdata[47:32];
    assign item.reported_state       = s_tdata[49:48];
    assign item.reported_incarnation = s_tdata[81:50];
    assign item.current_time         = s_tdata[113:82];

    assign s_tready = eng_idle;
    assign start    = s_tvalid && eng_idle;
    assign out_free = !out_valid_reg || m_tready;

    mrmt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .idle     (eng_idle),
        .res_push (eng_push),
        .res      (eng_res)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (eng_push)
        begin
            out_reg <= eng_res;
        end
    end

    // Pack the output transaction
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tlast  = out_reg.last_result;
    assign m_tdata  = {{(mrmt_pkg::M_TDATA_W - mrmt_pkg::M_FIELDS_W){1'b0}},
                       out_reg.own_incarnation_now,
                       out_reg.spread_again,
                       out_reg.member_incarnation,
                       out_reg.member_state,
                       out_reg.member_port,
                       out_reg.member_address};

endmodule

`default_nettype wire

// ===== hw/rtl/mrmt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module mrmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrmt_engine.sv =====
// ----------------------------------------------------------------------------
// Membership rumor merge table: scan and merge engine
// Sequencer that walks the member table one entry a cycle, save stalls for output room,
// through a single compare path, merges rumors, expires suspects and hands out results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "membership_rumor_merge_table_core_defines.svh"

module mrmt_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mrmt_pkg::item_t  item,
    input  wire mrmt_pkg::cfg_t   cfg,
    input  wire logic             out_free,
    output logic                  idle,
    output logic                  res_push,
    output mrmt_pkg::result_t     res
);

    mrmt_pkg::state_t  state_reg, state_next;
    logic [mrmt_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [mrmt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [mrmt_pkg::CNT_W-1:0] cnt_inc;
    mrmt_pkg::item_t   item_reg, item_next;
    mrmt_pkg::result_t hold_reg, hold_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [mrmt_pkg::INC_W-1:0] self_inc_reg, self_inc_next;
    logic [mrmt_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic              found_reg, found_next;
    logic              free_found_reg, free_found_next;
    logic [mrmt_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic [mrmt_pkg::IDX_W-1:0] free_reg, free_next;
    mrmt_pkg::entry_t  cur_reg, cur_next;
    logic [mrmt_pkg::TIME_W-1:0] deadline_reg, deadline_next;
    logic              empty_reg, empty_next;
    logic              self_reg, self_next;
    logic              refute_reg, refute_next;

    logic              ram_we;
    logic [mrmt_pkg::IDX_W-1:0] ram_waddr;
    mrmt_pkg::entry_t  ram_wdata;
    logic [$bits(mrmt_pkg::entry_t)-1:0] ram_rdata;
    mrmt_pkg::entry_t  rd_entry;

    logic [mrmt_pkg::EP_W-1:0]   ep_in;
    logic              last_idx;
    logic              expired;
    logic [mrmt_pkg::TIME_W:0]   arm_sum;
    logic [mrmt_pkg::INC_W-1:0]  bumped;
    logic              beats;
    logic [mrmt_pkg::STAT_W-1:0] st_clamped;

    assign rd_entry = mrmt_pkg::entry_t'(ram_rdata);
    assign ep_in    = {item_reg.subject_address, item_reg.subject_port};
    assign last_idx = (idx_reg == mrmt_pkg::IDX_W'(mrmt_pkg::TABLE_DEPTH - 1));
    assign cnt_inc  = cnt_reg + mrmt_pkg::CNT_W'(1);

    // Member table storage
    mrmt_ram #(
        .WIDTH ($bits(mrmt_pkg::entry_t)),
        .DEPTH (mrmt_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // Shared compare and add path
    assign expired = valid_reg[idx_reg]
                  && (rd_entry.status == mrmt_pkg::STAT_SUSPECT)
                  && (item_reg.current_time >= rd_entry.deadline);
    assign arm_sum = {1'b0, item_reg.current_time} + {1'b0, cfg.suspect_grace};
    assign bumped  = (item_reg.reported_incarnation == '1) ? '1
                   : item_reg.reported_incarnation + mrmt_pkg::INC_W'(1);
    assign beats   = (item_reg.reported_incarnation != cur_reg.incarnation)
                   ? (item_reg.reported_incarnation > cur_reg.incarnation)
                   : (item_reg.reported_state > cur_reg.status);
    assign st_clamped = (item.reported_state > mrmt_pkg::STAT_DEAD) ? mrmt_pkg::STAT_DEAD
                      : item.reported_state;

    // Hold control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mrmt_pkg::ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            self_inc_reg   <= '0;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            empty_reg      <= 1'b0;
            self_reg       <= 1'b0;
            refute_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            self_inc_reg   <= self_inc_next;
            valid_reg      <= valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            empty_reg      <= empty_next;
            self_reg       <= self_next;
            refute_reg     <= refute_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        hold_reg     <= hold_next;
        slot_reg     <= slot_next;
        free_reg     <= free_next;
        cur_reg      <= cur_next;
        deadline_reg <= deadline_next;
    end

    // Sequence the scan, merge and expiry
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        item_next       = item_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        self_inc_next   = self_inc_reg;
        valid_next      = valid_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        free_next       = free_reg;
        cur_next        = cur_reg;
        deadline_next   = deadline_reg;
        empty_next      = empty_reg;
        self_next       = self_reg;
        refute_next     = refute_reg;
        idle            = 1'b0;
        res_push        = 1'b0;
        res             = hold_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = rd_entry;

        case (state_reg)
            mrmt_pkg::ST_IDLE:
            begin
                idle     = 1'b1;
                idx_next = '0;
                if (start)
                begin
                    item_next                = item;
                    item_next.reported_state = st_clamped;
                    cnt_next                 = '0;
                    hold_valid_next          = 1'b0;
                    found_next               = 1'b0;
                    free_found_next          = 1'b0;
                    state_next = (item.kind == mrmt_pkg::KIND_TICK) ? mrmt_pkg::ST_TICK_SCAN
                               : mrmt_pkg::ST_CHECK;
                end
            end

            mrmt_pkg::ST_CHECK:
            begin
                // Classify the rumor and arm a deadline
                empty_next  = (item_reg.subject_address == '0) && (item_reg.subject_port == '0);
                self_next   = (item_reg.subject_address == cfg.own_address)
                           && (item_reg.subject_port == cfg.own_port);
                refute_next = (item_reg.reported_state != mrmt_pkg::STAT_ALIVE)
                           && (item_reg.reported_incarnation >= self_inc_reg);
                deadline_next = arm_sum[mrmt_pkg::TIME_W] ? '1
                              : arm_sum[mrmt_pkg::TIME_W-1:0];
                state_next = (empty_next || self_next) ? mrmt_pkg::ST_MERGE
                           : mrmt_pkg::ST_RUMOR_SCAN;
            end

            mrmt_pkg::ST_RUMOR_SCAN:
            begin
                // Stop at the first matching entry, note the lowest free one
                if (valid_reg[idx_reg] && (rd_entry.endpoint == ep_in))
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                    cur_next   = rd_entry;
                    state_next = mrmt_pkg::ST_MERGE;
                end
                else
                begin
                    if (!valid_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_next       = idx_reg;
                    end
                    if (last_idx)
                    begin
                        state_next = mrmt_pkg::ST_MERGE;
                    end
                    else
                    begin
                        idx_next = idx_reg + mrmt_pkg::IDX_W'(1);
                    end
                end
            end

            mrmt_pkg::ST_MERGE:
            begin
                if (out_free)
                begin
                    res_push               = 1'b1;
                    state_next             = mrmt_pkg::ST_IDLE;
                    res.event_res          = mrmt_pkg::EV_IGNORED;
                    res.member_address     = item_reg.subject_address;
                    res.member_port        = item_reg.subject_port;
                    res.member_state       = item_reg.reported_state;
                    res.member_incarnation = item_reg.reported_incarnation;
                    res.spread_again       = 1'b0;
                    res.last_result        = 1'b1;
                    ram_wdata.endpoint     = ep_in;
                    ram_wdata.status       = item_reg.reported_state;
                    ram_wdata.incarnation  = item_reg.reported_incarnation;
                    if (empty_reg)
                    begin
                        res.event_res = mrmt_pkg::EV_IGNORED;
                    end
                    else if (self_reg)
                    begin
                        // Refute a rumor about this node
                        if (refute_reg)
                        begin
                            self_inc_next    = bumped;
                            res.event_res    = mrmt_pkg::EV_REFUTED;
                            res.spread_again = 1'b1;
                        end
                        res.member_state       = mrmt_pkg::STAT_ALIVE;
                        res.member_incarnation = self_inc_next;
                    end
                    else if (!found_reg)
                    begin
                        if (free_found_reg)
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = free_reg;
                            ram_wdata.deadline =
                                (item_reg.reported_state == mrmt_pkg::STAT_SUSPECT)
                                ? deadline_reg : '0;
                            valid_next[free_reg] = 1'b1;
                            res.event_res      = mrmt_pkg::EV_LEARNED;
                            res.spread_again   = 1'b1;
                        end
                        else
                        begin
                            res.event_res = mrmt_pkg::EV_FULL;
                        end
                    end
                    else if (!beats)
                    begin
                        res.member_state       = cur_reg.status;
                        res.member_incarnation = cur_reg.incarnation;
                    end
                    else
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = slot_reg;
                        ram_wdata.deadline =
                            (item_reg.reported_state == mrmt_pkg::STAT_SUSPECT)
                            ? deadline_reg : cur_reg.deadline;
                        res.event_res      = (cur_reg.status != item_reg.reported_state)
                                           ? mrmt_pkg::EV_CHANGED : mrmt_pkg::EV_SAME;
                        res.spread_again   = 1'b1;
                    end
                    res.own_incarnation_now = self_inc_next;
                end
            end

            mrmt_pkg::ST_TICK_SCAN:
            begin
                if (expired)
                begin
                    // Mark dead; release the held result only when room exists
                    if (!hold_valid_reg || out_free)
                    begin
                        ram_we           = 1'b1;
                        ram_wdata.status = mrmt_pkg::STAT_DEAD;
                        res_push         = hold_valid_reg;
                        hold_valid_next  = 1'b1;
                        hold_next.event_res           = mrmt_pkg::EV_EXPIRED;
                        hold_next.member_address      =
                            rd_entry.endpoint[mrmt_pkg::EP_W-1:mrmt_pkg::PORT_W];
                        hold_next.member_port         =
                            rd_entry.endpoint[mrmt_pkg::PORT_W-1:0];
                        hold_next.member_state        = mrmt_pkg::STAT_DEAD;
                        hold_next.member_incarnation  = rd_entry.incarnation;
                        hold_next.spread_again        = 1'b1;
                        hold_next.own_incarnation_now = self_inc_reg;
                        hold_next.last_result         = 1'b0;
                        cnt_next = cnt_inc;
                        if (last_idx || (cnt_inc == mrmt_pkg::CNT_W'(mrmt_pkg::MAX_RESULTS)))
                        begin
                            state_next = mrmt_pkg::ST_TICK_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + mrmt_pkg::IDX_W'(1);
                        end
                    end
                end
                else if (last_idx)
                begin
                    state_next = mrmt_pkg::ST_TICK_DONE;
                end
                else
                begin
                    idx_next = idx_reg + mrmt_pkg::IDX_W'(1);
                end
            end

            mrmt_pkg::ST_TICK_DONE:
            begin
                // Close the tick with the held result or a quiet one
                if (out_free)
                begin
                    res_push        = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = mrmt_pkg::ST_IDLE;
                    if (hold_valid_reg)
                    begin
                        res.last_result = 1'b1;
                    end
                    else
                    begin
                        res.event_res           = mrmt_pkg::EV_IGNORED;
                        res.member_address      = '0;
                        res.member_port         = '0;
                        res.member_state        = mrmt_pkg::STAT_ALIVE;
                        res.member_incarnation  = '0;
                        res.spread_again        = 1'b0;
                        res.own_incarnation_now = self_inc_reg;
                        res.last_result         = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = mrmt_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencer
    `MRMT_ASSERT_IMP(a_idle_no_hold, state_reg == mrmt_pkg::ST_IDLE, !hold_valid_reg, "held result left behind in idle")
    `MRMT_ASSERT_IMP(a_push_has_room, res_push, out_free, "result pushed into a full output register")
    `MRMT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= mrmt_pkg::CNT_W'(mrmt_pkg::MAX_RESULTS), "tick result count beyond limit")
    `MRMT_ASSERT_IMP(a_write_states, ram_we, state_reg == mrmt_pkg::ST_TICK_SCAN || state_reg == mrmt_pkg::ST_MERGE, "table written outside merge or expiry")
    `MRMT_ASSERT_NXT(a_merge_ends, state_reg == mrmt_pkg::ST_MERGE && out_free, state_reg == mrmt_pkg::ST_IDLE, "merge did not finish once output was free")

endmodule

`default_nettype wire
